// ===== rtl/dwp_pkg.sv =====
// dwp_pkg: shared types, constants and the speed profile function for the
// dual wheel distance/speed profiler; no dependencies
package dwp_pkg;

	// one control tick, both wheels
	typedef struct packed {
		logic signed [15:0] left_target;
		logic signed [15:0] left_request;
		logic signed [15:0] left_count;
		logic signed [15:0] right_target;
		logic signed [15:0] right_request;
		logic signed [15:0] right_count;
	} tick_t;

	// one result per tick
	typedef struct packed {
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
		logic signed [15:0] left_remaining;
		logic signed [15:0] right_remaining;
	} result_t;

	// per-wheel lane output
	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [15:0] remaining;
	} lane_out_t;

	// profile thresholds and speeds
	localparam logic [16:0] MAG_NEAR  = 17'd10;
	localparam logic [16:0] MAG_MID   = 17'd25;
	localparam logic [16:0] MAG_FAR   = 17'd100;
	localparam logic [16:0] MAG_CAP   = 17'd300;
	localparam logic [8:0]  SPD_NEAR  = 9'd30;
	localparam logic [8:0]  SPD_MID   = 9'd50;
	localparam logic [8:0]  SPD_FAR   = 9'd100;
	localparam logic [8:0]  SPD_CAP   = 9'd300;

	// stepped speed from |rem|, or |rem| itself up to MAG_CAP; target's sign
	function automatic logic signed [15:0] profile_speed(
		input logic [15:0] rem,
		input logic        neg
	);
		logic [16:0] ext;
		logic [16:0] mag;
		logic [8:0]  spd;
		ext = {rem[15], rem};
		mag = rem[15] ? (~ext + 17'd1) : ext;
		if (mag == 17'd0)
			spd = 9'd0;
		else if (mag < MAG_NEAR)
			spd = SPD_NEAR;
		else if (mag < MAG_MID)
			spd = SPD_MID;
		else if (mag < MAG_FAR)
			spd = SPD_FAR;
		else if (mag < MAG_CAP)
			spd = mag[8:0];
		else
			spd = SPD_CAP;
		profile_speed = neg ? (16'sd0 - signed'({7'd0, spd})) : signed'({7'd0, spd});
	endfunction

endpackage

// ===== rtl/dual_wheel_distance_speed_profiler_unit.sv =====
// dual_wheel_distance_speed_profiler_unit: top level, two wheel lanes and the
// merged result register; depends on dwp_pkg, dwp_lane, dwp_out_buf
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------
//   tick    | tick_valid  | tick_stall  | tick   (dwp_pkg::tick_t)
//   prof    | prof_valid  | prof_stall  | prof   (dwp_pkg::result_t)
//
// a tick transaction is taken every cycle while tick_stall is low
// the result is registered in prof, or first in the skid entry while prof is stalled
// both lanes update their per-wheel state in the accept cycle, so ticks may
// follow back to back
// reset clears last target, start count and remaining distance of both wheels
// tick_stall rises only once a result is held in the skid entry behind a
// stalled output, i.e. two results are waiting
module dual_wheel_distance_speed_profiler_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  dwp_pkg::tick_t   tick,
	output logic             prof_valid,
	input  logic             prof_stall,
	output dwp_pkg::result_t prof
);

	logic               accept;
	logic               buf_full;
	dwp_pkg::lane_out_t left_res;
	dwp_pkg::lane_out_t right_res;
	dwp_pkg::result_t   merged;

	// accept whenever the skid entry is free
	assign tick_stall = buf_full;
	assign accept     = tick_valid && !buf_full;

	// left wheel lane
	dwp_lane u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.target  (tick.left_target),
		.request (tick.left_request),
		.count   (tick.left_count),
		.res     (left_res)
	);

	// right wheel lane
	dwp_lane u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.target  (tick.right_target),
		.request (tick.right_request),
		.count   (tick.right_count),
		.res     (right_res)
	);

	// merge the two lanes into one result
	always_comb begin
		merged.left_drive      = left_res.drive;
		merged.right_drive     = right_res.drive;
		merged.left_remaining  = left_res.remaining;
		merged.right_remaining = right_res.remaining;
	end

	dwp_out_buf u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (merged),
		.full   (buf_full),
		.valid  (prof_valid),
		.stall  (prof_stall),
		.dout   (prof)
	);

`ifndef SYNTHESIS
	// an accepted tick always leaves a result waiting next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> prof_valid)
		else $error("accepted tick produced no result");

	// the skid entry only fills behind a stalled output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> prof_valid && $past(prof_stall))
		else $error("skid entry full without a stalled output");

	// left remainder never crosses to the opposite sign of a nonnegative target
	a_left_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !tick.left_target[15]) |-> !left_res.remaining[15])
		else $error("left remainder has wrong sign");
`endif

endmodule

// ===== rtl/dwp_lane.sv =====
// dwp_lane: one wheel's distance tracker and speed selector with its state
// depends on dwp_pkg
module dwp_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [15:0] target,
	input  logic signed [15:0] request,
	input  logic signed [15:0] count,
	output dwp_pkg::lane_out_t res
);

	logic [15:0] last_target_q;
	logic [15:0] start_count_q;
	logic [15:0] remaining_q;

	logic        changed;
	logic [15:0] start_n;
	logic [15:0] rem_load;
	logic [15:0] moved;
	logic [15:0] diff;
	logic [15:0] rem_n;

	always_comb begin
		changed  = target != last_target_q;
		start_n  = changed ? count : start_count_q;
		rem_load = changed ? target : remaining_q;
		moved    = count - start_n;
		diff     = target - moved;
		rem_n    = rem_load;
		if (rem_load != 16'd0) begin
			// clamp at zero toward the sign of the target
			if (!target[15])
				rem_n = diff[15] ? 16'd0 : diff;
			else
				rem_n = (!diff[15] && diff != 16'd0) ? 16'd0 : diff;
		end
		res.remaining = signed'(rem_n);
		res.drive     = (request != 16'sd0) ? request
			: dwp_pkg::profile_speed(rem_n, target[15]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_target_q <= '0;
			start_count_q <= '0;
			remaining_q   <= '0;
		end else if (en) begin
			last_target_q <= target;
			start_count_q <= start_n;
			remaining_q   <= rem_n;
		end
	end

endmodule

// ===== rtl/dwp_out_buf.sv =====
// dwp_out_buf: merged result register with a skid entry behind it
// depends on dwp_pkg
module dwp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dwp_pkg::result_t din,
	output logic             full,
	output logic             valid,
	input  logic             stall,
	output dwp_pkg::result_t dout
);

	logic             out_valid_q;
	logic             skid_valid_q;
	dwp_pkg::result_t out_q;
	dwp_pkg::result_t skid_q;
	logic             free;

	assign free  = !out_valid_q || !stall;
	assign full  = skid_valid_q;
	assign valid = out_valid_q;
	assign dout  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= din;
		end else if (push) begin
			skid_q <= din;
		end
	end

endmodule

// ===== dv/tb_dual_wheel_distance_speed_profiler_unit.sv =====
`timescale 1ns / 1ps
// tb_dual_wheel_distance_speed_profiler_unit: self-checking bench for the dual wheel
// distance/speed profiler, own lane predictor, driver and monitor; depends on dwp_pkg
// and the dual_wheel_distance_speed_profiler_unit rtl
module tb_dual_wheel_distance_speed_profiler_unit;

	// profile bands, per wheel
	localparam int BAND_NEAR = 10;
	localparam int BAND_MID  = 25;
	localparam int BAND_FAR  = 100;
	localparam int BAND_CAP  = 300;
	localparam int SPEED_NEAR = 30;
	localparam int SPEED_MID  = 50;
	localparam int SPEED_FAR  = 100;
	localparam int SPEED_CAP  = 300;
	localparam int LEFT  = 0;
	localparam int RIGHT = 1;
	localparam int HOLD_CYCLES = 250;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             tick_valid = 1'b0;
	logic             tick_stall;
	dwp_pkg::tick_t   tick = '0;
	logic             prof_valid;
	logic             prof_stall = 1'b0;
	dwp_pkg::result_t prof;

	dwp_pkg::tick_t   tick_pend_q[$];     // transactions waiting to be offered
	dwp_pkg::result_t profile_due_q[$];   // predicted results, oldest first
	logic             tick_taken = 1'b0;
	logic             quiet = 1'b0;       // no idling on either side
	int               hold_asks = 0;
	int               holds_served = 0;
	int               hold_left = 0;
	int               mism_cnt = 0;
	dwp_pkg::result_t got;
	dwp_pkg::result_t want;

	// predictor state per wheel
	logic [15:0] whl_last [2];
	logic [15:0] whl_start [2];
	logic [15:0] whl_rem [2];

	// stimulus generator state per wheel
	logic [15:0] gen_tgt [2];
	logic [15:0] gen_pos [2];

	dual_wheel_distance_speed_profiler_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.prof_valid (prof_valid),
		.prof_stall (prof_stall),
		.prof       (prof)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// one wheel for one tick: latch on a new target, track and clamp, then pick the speed
	function automatic logic [15:0] lane_speed(input int w, input logic [15:0] tgt,
		input logic [15:0] req, input logic [15:0] cnt);
		logic [15:0] moved;
		logic [15:0] diff;
		int r;
		int mag;
		int spd;
		if (tgt != whl_last[w]) begin
			whl_start[w] = cnt;
			whl_rem[w]   = tgt;
			whl_last[w]  = tgt;
		end
		if (whl_rem[w] != 16'd0) begin
			moved = cnt - whl_start[w];
			diff  = tgt - moved;
			if (!tgt[15]) begin
				if (diff[15])
					diff = 16'd0;
			end else begin
				// negative target: a positive remainder means overshoot
				if (!diff[15] && diff != 16'd0)
					diff = 16'd0;
			end
			whl_rem[w] = diff;
		end
		if (req != 16'd0)
			return req;
		r   = int'($signed(whl_rem[w]));
		mag = (r < 0) ? -r : r;
		if (mag == 0)
			spd = 0;
		else if (mag < BAND_NEAR)
			spd = SPEED_NEAR;
		else if (mag < BAND_MID)
			spd = SPEED_MID;
		else if (mag < BAND_FAR)
			spd = SPEED_FAR;
		else if (mag < BAND_CAP)
			spd = mag;
		else
			spd = SPEED_CAP;
		if (tgt[15])
			spd = -spd;
		return spd[15:0];
	endfunction

	function automatic dwp_pkg::result_t profile_tick(input dwp_pkg::tick_t t);
		dwp_pkg::result_t p;
		p.left_drive      = lane_speed(LEFT, t.left_target, t.left_request, t.left_count);
		p.right_drive     = lane_speed(RIGHT, t.right_target, t.right_request, t.right_count);
		p.left_remaining  = whl_rem[LEFT];
		p.right_remaining = whl_rem[RIGHT];
		return p;
	endfunction

	task automatic note_mismatch(input string what, input logic [15:0] e, input logic [15:0] a);
		mism_cnt++;
		if (mism_cnt <= 10)
			$display("mismatch %s: expected %0d (%h) got %0d (%h)", what,
				$signed(e), e, $signed(a), a);
	endtask

	// driver: new transaction only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!tick_valid || tick_taken) begin
				if (tick_pend_q.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
					tick       <= tick_pend_q.pop_front();
					tick_valid <= 1'b1;
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: long hold-off on request, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			prof_stall <= 1'b1;
			hold_left  <= hold_left - 1;
		end else if (hold_asks != holds_served) begin
			prof_stall   <= 1'b1;
			hold_left    <= HOLD_CYCLES - 1;
			holds_served <= holds_served + 1;
		end else begin
			prof_stall <= quiet ? 1'b0 : ($urandom_range(99) < 35);
		end
	end

	// monitor: check results first, then predict for the transaction taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (prof_valid && !prof_stall) begin
				got = prof;
				if (profile_due_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("unexpected result %h with nothing predicted", got);
				end else begin
					want = profile_due_q.pop_front();
					if (got.left_drive != want.left_drive)
						note_mismatch("left_drive", want.left_drive, got.left_drive);
					if (got.right_drive != want.right_drive)
						note_mismatch("right_drive", want.right_drive, got.right_drive);
					if (got.left_remaining != want.left_remaining)
						note_mismatch("left_remaining", want.left_remaining, got.left_remaining);
					if (got.right_remaining != want.right_remaining)
						note_mismatch("right_remaining", want.right_remaining,
							got.right_remaining);
				end
			end
			if (tick_valid && !tick_stall)
				profile_due_q.push_back(profile_tick(tick));
			tick_taken <= tick_valid && !tick_stall;
		end
	end

	task automatic push_tick(input int lt, input int lr, input int lc,
		input int rt, input int rr, input int rc);
		dwp_pkg::tick_t t;
		t.left_target   = lt[15:0];
		t.left_request  = lr[15:0];
		t.left_count    = lc[15:0];
		t.right_target  = rt[15:0];
		t.right_request = rr[15:0];
		t.right_count   = rc[15:0];
		tick_pend_q.push_back(t);
	endtask

	// one wheel of a move: occasional new target, count stepping toward it
	task automatic gen_lane(input int w, output logic [15:0] t, output logic [15:0] r,
		output logic [15:0] c);
		int k;
		int m;
		int dir;
		int s;
		k = $urandom_range(99);
		if (k < 7) begin
			k = $urandom_range(99);
			if (k < 10) begin
				gen_tgt[w] = 16'd0;
			end else if (k < 70) begin
				m = $urandom_range(1, 400);
				gen_tgt[w] = 16'($urandom_range(1) ? m : -m);
			end else if (k < 85) begin
				gen_tgt[w] = 16'($urandom_range(65535));
			end else begin
				case ($urandom_range(3))
					0: gen_tgt[w] = 16'h7fff;
					1: gen_tgt[w] = 16'h8000;
					2: gen_tgt[w] = 16'hffff;
					default: gen_tgt[w] = 16'h0001;
				endcase
			end
			if ($urandom_range(1))
				gen_pos[w] = 16'($urandom_range(65535));
		end else begin
			dir = gen_tgt[w][15] ? -1 : 1;
			s   = $urandom_range(0, 30);
			k   = $urandom_range(99);
			if (k < 8)
				gen_pos[w] = 16'(int'(gen_pos[w]) - dir * s);
			else if (k < 11)
				gen_pos[w] = 16'($urandom_range(65535));
			else
				gen_pos[w] = 16'(int'(gen_pos[w]) + dir * s);
		end
		k = $urandom_range(99);
		if (k < 75)
			r = 16'd0;
		else if (k < 90)
			r = 16'($urandom_range(65535));
		else begin
			m = $urandom_range(1, 200);
			r = 16'($urandom_range(1) ? m : -m);
		end
		t = gen_tgt[w];
		c = gen_pos[w];
	endtask

	task automatic queue_moves(input int n);
		dwp_pkg::tick_t t;
		for (int i = 0; i < n; i++) begin
			gen_lane(LEFT, t.left_target, t.left_request, t.left_count);
			gen_lane(RIGHT, t.right_target, t.right_request, t.right_count);
			tick_pend_q.push_back(t);
		end
	endtask

	task automatic queue_noise(input int n);
		for (int i = 0; i < n; i++)
			push_tick($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
	endtask

	// sender pause: everything offered, taken and answered
	task automatic drain;
		while (tick_pend_q.size() != 0 || tick_valid)
			@(negedge clk);
		while (profile_due_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		for (int w = 0; w < 2; w++) begin
			whl_last[w]  = 16'd0;
			whl_start[w] = 16'd0;
			whl_rem[w]   = 16'd0;
			gen_tgt[w]   = 16'd0;
			gen_pos[w]   = 16'd0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: idle at reset, request pass-through, every profile band, clamps,
		// target back to zero, most negative remainder, count wrap
		push_tick(0, 0, 0, 0, 0, 0);
		push_tick(0, 5, 1234, 0, -1, -32768);
		push_tick(5, 0, 100, -5, 0, 100);
		push_tick(20, 0, 0, -20, 0, 0);
		push_tick(50, 0, 0, -50, 0, 0);
		push_tick(200, 0, 0, -200, 0, 0);
		push_tick(1000, 0, 0, -1000, 0, 0);
		push_tick(1000, 0, 990, -1000, 0, -990);
		push_tick(1000, 0, 1000, -1000, 0, -1000);
		push_tick(1000, 0, 500, -1000, 0, -500);
		push_tick(1000, 32767, -32768, -1000, -32768, 32767);
		push_tick(32767, 0, 0, -32768, 0, 0);
		push_tick(32767, 0, -1, -32768, 0, 1);
		push_tick(0, 0, 7, 0, 0, 7);
		push_tick(-1, 0, 7, 1, 0, 7);
		push_tick(-1, 0, 8, 1, 0, 6);
		push_tick(-1, 0, 6, 1, 0, 8);
		push_tick(-32768, -32768, -32768, 32767, 32767, 32767);
		push_tick(150, 0, 32767, 150, 0, -32768);
		push_tick(150, 0, -32669, 150, 0, -32628);
		push_tick(-300, 0, 0, -299, 0, 0);
		push_tick(-10, 0, 0, 25, 0, 0);
		push_tick(-9, 0, 0, 24, 0, 0);
		push_tick(99, 0, 0, -100, 0, 0);
		drain();

		queue_moves(300);
		drain();

		// no idling, receiver holds off first so the block backs up into the sender
		@(posedge clk);
		quiet = 1'b1;
		hold_asks = hold_asks + 1;
		queue_moves(200);
		drain();
		@(posedge clk);
		quiet = 1'b0;

		queue_moves(250);
		queue_noise(150);
		drain();

		repeat (5) @(negedge clk);
		if (mism_cnt == 0 && profile_due_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule
